// File: hw/rtl/gdd_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date decrement core.
// Used by every module under hw/rtl but the checker; depends on nothing else.
`timescale 1ns / 1ps

package gdd_pkg;

    // Field widths fixed by the item format.
    localparam int FUNC_W  = 3;
    localparam int AMT_W   = 10;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;

    // Largest count honored; larger counts saturate.
    localparam logic [AMT_W-1:0] MAX_AMOUNT = 10'd1023;

    // Step counter covers the week mode worst case (seven days per unit).
    localparam int CNT_W = $clog2(1023 * 7 + 1);

    // Residue of the year modulo 25 drives the century part of the leap rule.
    localparam int RES_W = 5;
    localparam logic [RES_W-1:0] RES_MOD = 5'd25;

    // Reciprocal of 25 scaled by 2^16 and rounded down; the quotient is low by at most one.
    localparam logic [11:0] RES_RECIP = 12'd2621;

    // Mode codes.
    localparam logic [FUNC_W-1:0] FUNC_DAYS    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WEEKS   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MONTHS  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_YEARS   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DECADES = 3'd4;

    // Month numbers with special handling.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Working date plus the year's residue modulo 25.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [RES_W-1:0]   res;
    } date_t;

    // Length of a month; February depends on the leap flag.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/gdd_res25.sv
// Pipelined unit that reduces a 16-bit two's complement year modulo 25.
// Depends on gdd_pkg; done follows start through the valid bits v1_reg, v2_reg and v3_reg, with the residue.
`timescale 1ns / 1ps

module gdd_res25 (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [gdd_pkg::YEAR_W-1:0] year,
    output logic                      done,
    output logic [gdd_pkg::RES_W-1:0]  res
);

    logic [gdd_pkg::YEAR_W-1:0] y_reg;
    logic [gdd_pkg::YEAR_W:0]   w_reg;
    logic [gdd_pkg::YEAR_W:0]   w3_reg;
    logic [12:0]                q_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic [28:0]                prod;
    logic [gdd_pkg::YEAR_W:0]   q25;
    logic [gdd_pkg::YEAR_W:0]   rem;
    logic [5:0]                 rem6;

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Quotient estimate by reciprocal multiplication.
    assign prod = 29'(w_reg) * 29'(gdd_pkg::RES_RECIP);

    // A negative year reads 65536 too high, and 65536 is 11 mod 25: add 14 first.
    always_ff @(posedge aclk) begin
        if (start) begin
            y_reg <= year;
        end
        w_reg  <= {1'b0, y_reg} + (y_reg[gdd_pkg::YEAR_W-1] ? 17'd14 : 17'd0);
        q_reg  <= prod[28:16];
        w3_reg <= w_reg;
    end

    // Remainder lies in 0..49, so one compare and subtract finishes it.
    always_comb begin
        q25  = 17'({q_reg, 4'b0000}) + 17'({q_reg, 3'b000}) + 17'(q_reg);
        rem  = w3_reg - q25;
        rem6 = rem[5:0];
        if (rem6 >= 6'(gdd_pkg::RES_MOD)) begin
            res = 5'(rem6 - 6'(gdd_pkg::RES_MOD));
        end else begin
            res = rem6[4:0];
        end
    end

    assign done = v3_reg;

endmodule

// File: hw/rtl/gdd_step.sv
// Shared date step unit: moves a date back by one day or one month.
// Depends on gdd_pkg; purely combinational, applied once per cycle by the top level.
`timescale 1ns / 1ps

module gdd_step (
    input  gdd_pkg::date_t cur,
    input  logic           month_mode,
    output gdd_pkg::date_t nxt
);

    logic                        leap;
    logic                        wrap;
    logic [gdd_pkg::MONTH_W-1:0] prev_m;
    logic [gdd_pkg::DAY_W-1:0]   len;
    logic [gdd_pkg::YEAR_W-1:0]  year_dec;
    logic [gdd_pkg::RES_W-1:0]   res_dec;

    // Leap year: divisible by 4 and either not by 25 or also by 16.
    assign leap = (cur.year[1:0] == 2'b00) && ((cur.res != '0) || (cur.year[3:0] == 4'b0000));

    // Previous month; January rolls back to December of the year before.
    assign wrap   = (cur.month == gdd_pkg::MONTH_JAN);
    assign prev_m = wrap ? gdd_pkg::MONTH_DEC : cur.month - 4'd1;
    assign len    = gdd_pkg::month_days(prev_m, leap);

    // Year decrement with its residue; the most negative year wraps to 32767, which is 17 mod 25.
    always_comb begin
        year_dec = cur.year - 16'd1;
        if (cur.year == 16'h8000) begin
            res_dec = 5'd17;
        end else if (cur.res == '0) begin
            res_dec = 5'(gdd_pkg::RES_MOD - 5'd1);
        end else begin
            res_dec = cur.res - 5'd1;
        end
    end

    // Next date.
    always_comb begin
        nxt = cur;
        if (!month_mode && (cur.day > 5'd1)) begin
            nxt.day = cur.day - 5'd1;
        end else begin
            nxt.month = prev_m;
            if (wrap) begin
                nxt.year = year_dec;
                nxt.res  = res_dec;
            end
            if (!month_mode || (cur.day > len)) begin
                nxt.day = len;
            end
        end
    end

endmodule

// File: hw/rtl/gregorian_date_decrement_core.sv
// Top level of the Gregorian date decrement core: stream ports, sequencer, output register.
// Depends on gdd_pkg, gdd_res25 and gdd_step.
`timescale 1ns / 1ps

// The core takes one item at a time: it is ready only when idle. After an item is
// accepted, a small pipelined unit reduces the year modulo 25 for the leap rule,
// then the shared step unit moves the date back one day (day and week modes) or
// one month (month mode) per cycle. Year and decade modes are done at accept time.
// The number of steps is the count for day and month modes, seven times the count
// for week mode (at most 7161), and zero otherwise. The result sits in an output
// register until taken, and the next item can be accepted in the cycle after the
// result is loaded.

module gregorian_date_decrement_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0], amount[12:3], day_in[17:13], month_in[21:18], year_in[37:22], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_out[4:0], month_out[8:5], year_out[24:9], zero fill
    output logic [31:0] m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RES  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                  state_reg;
    logic [gdd_pkg::CNT_W-1:0]   cnt_reg;
    logic                        mmode_reg;
    gdd_pkg::date_t              date_reg;
    gdd_pkg::date_t              date_step;
    logic                        m_valid_reg;
    logic [gdd_pkg::DAY_W-1:0]   day_out_reg;
    logic [gdd_pkg::MONTH_W-1:0] month_out_reg;
    logic [gdd_pkg::YEAR_W-1:0]  year_out_reg;

    logic                        accept;
    logic [gdd_pkg::FUNC_W-1:0]  func;
    logic [gdd_pkg::AMT_W-1:0]   amount_raw, amount;
    logic [gdd_pkg::DAY_W-1:0]   day_in;
    logic [gdd_pkg::MONTH_W-1:0] month_in;
    logic [gdd_pkg::YEAR_W-1:0]  year_in;
    logic [gdd_pkg::DAY_W-1:0]   day_fix;
    logic [gdd_pkg::MONTH_W-1:0] month_fix;
    logic [13:0]                 tens;
    logic [gdd_pkg::YEAR_W-1:0]  year_load;
    logic [gdd_pkg::CNT_W-1:0]   cnt_load;
    logic                        res_done;
    logic [gdd_pkg::RES_W-1:0]   res_val;
    logic                        out_free;

    // Input unpacking and range corrections.
    assign accept     = s_tvalid && s_tready;
    assign func       = s_tdata[2:0];
    assign amount_raw = s_tdata[12:3];
    assign day_in     = s_tdata[17:13];
    assign month_in   = s_tdata[21:18];
    assign year_in    = s_tdata[37:22];

    assign amount    = (amount_raw > gdd_pkg::MAX_AMOUNT) ? gdd_pkg::MAX_AMOUNT : amount_raw;
    assign day_fix   = (day_in == '0) ? 5'd1 : day_in;
    assign month_fix = (month_in == '0) ? gdd_pkg::MONTH_JAN :
                       (month_in > gdd_pkg::MONTH_DEC) ? gdd_pkg::MONTH_DEC : month_in;
    assign tens      = 14'({amount, 3'b000}) + 14'({amount, 1'b0});

    // Year and decade modes finish at accept; the other modes load a step count.
    always_comb begin
        year_load = year_in;
        cnt_load  = '0;
        case (func)
            gdd_pkg::FUNC_DAYS:    cnt_load  = gdd_pkg::CNT_W'(amount);
            gdd_pkg::FUNC_WEEKS:   cnt_load  = gdd_pkg::CNT_W'({amount, 3'b000})
                                               - gdd_pkg::CNT_W'(amount);
            gdd_pkg::FUNC_MONTHS:  cnt_load  = gdd_pkg::CNT_W'(amount);
            gdd_pkg::FUNC_YEARS:   year_load = year_in - 16'(amount);
            gdd_pkg::FUNC_DECADES: year_load = year_in - 16'(tens);
            default:               cnt_load  = '0;
        endcase
    end

    // Residue unit and shared step unit.
    gdd_res25 u_res25 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .year    (year_load),
        .done    (res_done),
        .res     (res_val)
    );

    gdd_step u_step (
        .cur        (date_reg),
        .month_mode (mmode_reg),
        .nxt        (date_step)
    );

    assign out_free = !m_valid_reg || m_tready;

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !((state_reg == ST_DONE) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_RES;
                    end
                end
                ST_RES: begin
                    if (res_done) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Working date, step counter and output register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            date_reg.day   <= day_fix;
            date_reg.month <= month_fix;
            date_reg.year  <= year_load;
            date_reg.res   <= '0;
            cnt_reg        <= cnt_load;
            mmode_reg      <= (func == gdd_pkg::FUNC_MONTHS);
        end else if ((state_reg == ST_RES) && res_done) begin
            date_reg.res <= res_val;
        end else if ((state_reg == ST_RUN) && (cnt_reg != '0)) begin
            date_reg <= date_step;
            cnt_reg  <= cnt_reg - gdd_pkg::CNT_W'(1);
        end
        if ((state_reg == ST_DONE) && out_free) begin
            day_out_reg   <= date_reg.day;
            month_out_reg <= date_reg.month;
            year_out_reg  <= date_reg.year;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, year_out_reg, month_out_reg, day_out_reg};

endmodule

// File: hw/rtl/gdd_checker.sv
// Port-level checker for the Gregorian date decrement core, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module gdd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A result not taken holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: no new item right after one is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // The year reduction keeps a fresh result from appearing right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // Delivered month is a real month and the day is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12) &&
                     (m_tdata[4:0] != 5'd0))
        else $error("result date out of range");

endmodule

bind gregorian_date_decrement_core gdd_checker u_gdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
